// ----- hdl/tmbb_pkg.sv -----
// Shared constants, action codes and controller/datapath interface types.
package tmbb_pkg;

	localparam int GROUP_COUNT_DEF = 4;
	localparam int GROUP_BYTES_DEF = 64;
	localparam int HEADER_LEN      = 4;
	localparam logic [31:0] TIMEOUT_RESET = 32'd5000;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_BYTE  = 2'd2;
	localparam logic [1:0] ACT_EXEC  = 2'd3;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_BYTE   = 1'b1;
	localparam logic STAT_OK     = 1'b0;
	localparam logic STAT_BUSY   = 1'b1;

	typedef struct packed {
		logic       load;
		logic       do_tick;
		logic       do_pay;
		logic       do_claim;
		logic       do_find;
		logic       do_accept;
		logic       do_busy;
		logic       hdr_wr;
		logic [1:0] hdr_idx;
		logic       free_g;
		logic       rcnt_clr;
		logic       rcnt_inc;
		logic       rd_issue;
		logic       out_load;
		logic       out_kind;
		logic       out_status;
	} cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       gval;
		logic       fits;
		logic       fill_zero;
		logic       rlast;
		logic       out_free;
	} sts_t;

endpackage

// ----- hdl/tmbb_ctrl.sv -----
// Sequencing state machine for the message batch buffer.
module tmbb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  tmbb_pkg::sts_t sts,
	output tmbb_pkg::cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_FIT  = 3'd2;
	localparam logic [2:0] S_HDR  = 3'd3;
	localparam logic [2:0] S_STAT = 3'd4;
	localparam logic [2:0] S_XCHK = 3'd5;
	localparam logic [2:0] S_RD   = 3'd6;
	localparam logic [2:0] S_RW   = 3'd7;

	logic [2:0] state_q, state_d;
	logic [1:0] hcnt_q, hcnt_d;
	logic       stat_q, stat_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		hcnt_d  = hcnt_q;
		stat_d  = stat_q;
		cmd     = '0;
		cmd.hdr_idx = hcnt_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EVAL;
				end
			end
			S_EVAL: begin
				case (sts.action)
					tmbb_pkg::ACT_TICK: begin
						cmd.do_tick = 1'b1;
						state_d     = S_IDLE;
					end
					tmbb_pkg::ACT_START: begin
						cmd.do_claim = 1'b1;
						state_d      = S_FIT;
					end
					tmbb_pkg::ACT_BYTE: begin
						cmd.do_pay = 1'b1;
						state_d    = S_IDLE;
					end
					default: begin
						cmd.do_find = 1'b1;
						state_d     = S_XCHK;
					end
				endcase
			end
			S_FIT: begin
				if (!sts.gval || !sts.fits) begin
					cmd.do_busy = 1'b1;
					stat_d      = tmbb_pkg::STAT_BUSY;
					state_d     = S_STAT;
				end else begin
					cmd.do_accept = 1'b1;
					hcnt_d        = 2'd0;
					state_d       = S_HDR;
				end
			end
			S_HDR: begin
				cmd.hdr_wr = 1'b1;
				hcnt_d     = hcnt_q + 2'd1;
				if (hcnt_q == 2'd3) begin
					stat_d  = tmbb_pkg::STAT_OK;
					state_d = S_STAT;
				end
			end
			S_STAT: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_kind   = tmbb_pkg::KIND_STATUS;
					cmd.out_status = stat_q;
					state_d        = S_IDLE;
				end
			end
			S_XCHK: begin
				stat_d = tmbb_pkg::STAT_OK;
				if (!sts.gval) begin
					state_d = S_STAT;
				end else if (sts.fill_zero) begin
					cmd.free_g = 1'b1;
					state_d    = S_STAT;
				end else begin
					cmd.rcnt_clr = 1'b1;
					state_d      = S_RD;
				end
			end
			S_RD: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_RW;
			end
			S_RW: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_kind   = tmbb_pkg::KIND_BYTE;
					cmd.out_status = tmbb_pkg::STAT_OK;
					if (sts.rlast) begin
						cmd.free_g = 1'b1;
						state_d    = S_IDLE;
					end else begin
						cmd.rcnt_inc = 1'b1;
						state_d      = S_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hcnt_q  <= 2'd0;
			stat_q  <= tmbb_pkg::STAT_OK;
		end else begin
			state_q <= state_d;
			hcnt_q  <= hcnt_d;
			stat_q  <= stat_d;
		end
	end

endmodule

// ----- hdl/tmbb_dp.sv -----
// Datapath: group table, byte store, item latch and output register.
module tmbb_dp #(
	parameter int GROUP_COUNT = tmbb_pkg::GROUP_COUNT_DEF,
	parameter int GROUP_BYTES = tmbb_pkg::GROUP_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tmbb_pkg::cmd_t cmd,
	output tmbb_pkg::sts_t sts,
	input  logic          cfg_valid,
	input  logic [31:0]   cfg_data,
	input  logic [1:0]    action,
	input  logic [31:0]   now_ms,
	input  logic [7:0]    tag,
	input  logic [15:0]   entry_type,
	input  logic [15:0]   body_len,
	input  logic [7:0]    data_byte,
	input  logic          out_stall,
	output logic          out_valid,
	output logic          kind,
	output logic          status,
	output logic [7:0]    replay_byte,
	output logic          last
);

	localparam int GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
	localparam int FW = $clog2(GROUP_BYTES + 1);
	localparam int AW = $clog2(GROUP_COUNT * GROUP_BYTES);

	logic [31:0] timeout_q;
	logic [1:0]  action_q;
	logic [31:0] now_q;
	logic [7:0]  tag_q;
	logic [15:0] type_q;
	logic [15:0] plen_q;
	logic [7:0]  data_q;

	logic          active_q [GROUP_COUNT];
	logic [7:0]    gtag_q   [GROUP_COUNT];
	logic [FW-1:0] fill_q   [GROUP_COUNT];
	logic [31:0]   stamp_q  [GROUP_COUNT];

	logic [GW-1:0] wg_q, g_q;
	logic          gval_q;
	logic [15:0]   pending_q;
	logic          dropping_q;
	logic [FW-1:0] ridx_q;

	logic [7:0] mem_q [GROUP_COUNT * GROUP_BYTES];
	logic [7:0] rdata_q;

	logic          out_valid_q, kind_q, status_q, last_q;
	logic [7:0]    byte_q;

	// tag match and lowest free slot
	logic          found, free_ok;
	logic [GW-1:0] fidx, freeidx;
	always_comb begin
		found   = 1'b0;
		free_ok = 1'b0;
		fidx    = '0;
		freeidx = '0;
		for (int i = 0; i < GROUP_COUNT; i++) begin
			if (!found && active_q[i] && gtag_q[i] == tag_q) begin
				found = 1'b1;
				fidx  = GW'(i);
			end
			if (!free_ok && !active_q[i]) begin
				free_ok = 1'b1;
				freeidx = GW'(i);
			end
		end
	end

	logic [FW-1:0] gfill;
	logic [16:0]   need;
	assign gfill = fill_q[g_q];
	assign need  = 17'(gfill) + 17'(tmbb_pkg::HEADER_LEN) + 17'(plen_q);

	logic pay_ok;
	assign pay_ok = cmd.do_pay && pending_q != 16'd0 && !dropping_q && active_q[wg_q] &&
		(fill_q[wg_q] < FW'(GROUP_BYTES));

	logic [GW-1:0] wgrp;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata;
	logic          we;
	assign wgrp  = cmd.hdr_wr ? g_q : wg_q;
	assign waddr = AW'(wgrp) * AW'(GROUP_BYTES) + AW'(fill_q[wgrp]);
	assign raddr = AW'(g_q) * AW'(GROUP_BYTES) + AW'(ridx_q);
	assign we    = cmd.hdr_wr || pay_ok;
	always_comb begin
		wdata = data_q;
		if (cmd.hdr_wr) begin
			case (cmd.hdr_idx)
				2'd0:    wdata = type_q[7:0];
				2'd1:    wdata = type_q[15:8];
				2'd2:    wdata = plen_q[7:0];
				default: wdata = plen_q[15:8];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (cmd.rd_issue)
			rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			now_q    <= now_ms;
			tag_q    <= tag;
			type_q   <= entry_type;
			plen_q   <= body_len;
			data_q   <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= tmbb_pkg::TIMEOUT_RESET;
		end else if (cfg_valid) begin
			timeout_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GROUP_COUNT; i++) begin
				active_q[i] <= 1'b0;
				gtag_q[i]   <= '0;
				fill_q[i]   <= '0;
				stamp_q[i]  <= '0;
			end
			wg_q       <= '0;
			g_q        <= '0;
			gval_q     <= 1'b0;
			pending_q  <= '0;
			dropping_q <= 1'b0;
			ridx_q     <= '0;
		end else begin
			if (cmd.do_claim) begin
				gval_q <= found || free_ok;
				g_q    <= found ? fidx : freeidx;
				if (!found && free_ok) begin
					active_q[freeidx] <= 1'b1;
					gtag_q[freeidx]   <= tag_q;
					fill_q[freeidx]   <= '0;
				end
			end
			if (cmd.do_find) begin
				gval_q <= found;
				g_q    <= fidx;
			end
			if (cmd.do_tick) begin
				for (int i = 0; i < GROUP_COUNT; i++) begin
					if (active_q[i] && (now_q - stamp_q[i]) > timeout_q) begin
						active_q[i] <= 1'b0;
						fill_q[i]   <= '0;
						if (wg_q == GW'(i)) begin
							pending_q  <= '0;
							dropping_q <= 1'b0;
						end
					end
				end
			end
			if (cmd.do_pay && pending_q != 16'd0)
				pending_q <= pending_q - 16'd1;
			if (pay_ok)
				fill_q[wg_q] <= fill_q[wg_q] + FW'(1);
			if (cmd.do_accept) begin
				stamp_q[g_q] <= now_q;
				wg_q         <= g_q;
				pending_q    <= plen_q;
				dropping_q   <= 1'b0;
			end
			if (cmd.do_busy) begin
				pending_q  <= plen_q;
				dropping_q <= 1'b1;
			end
			if (cmd.hdr_wr)
				fill_q[g_q] <= fill_q[g_q] + FW'(1);
			if (cmd.free_g) begin
				active_q[g_q] <= 1'b0;
				fill_q[g_q]   <= '0;
				if (wg_q == g_q) begin
					pending_q  <= '0;
					dropping_q <= 1'b0;
				end
			end
			if (cmd.rcnt_clr)
				ridx_q <= '0;
			else if (cmd.rcnt_inc)
				ridx_q <= ridx_q + FW'(1);
		end
	end

	logic rlast;
	assign rlast = (ridx_q + FW'(1)) == gfill;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			kind_q   <= cmd.out_kind;
			status_q <= cmd.out_status;
			byte_q   <= (cmd.out_kind == tmbb_pkg::KIND_BYTE) ? rdata_q : 8'd0;
			last_q   <= (cmd.out_kind == tmbb_pkg::KIND_STATUS) || rlast;
		end
	end

	assign sts.action    = action_q;
	assign sts.gval      = gval_q;
	assign sts.fits      = need <= 17'(GROUP_BYTES);
	assign sts.fill_zero = gfill == '0;
	assign sts.rlast     = rlast;
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign status      = status_q;
	assign replay_byte = byte_q;
	assign last        = last_q;

endmodule

// ----- hdl/tagged_message_batch_buffer.sv -----
// Top level of the tagged message batch buffer: controller, datapath and checks.
// One item is in work at a time. An accepted message start writes its four header bytes
// one after another through the single store write port, and an execute of a stored group
// sends each byte through the registered store read before the output register; output
// stall can hold an item in work longer. The byte store needs no clearing after reset.
module tagged_message_batch_buffer #(
	parameter int GROUP_COUNT = tmbb_pkg::GROUP_COUNT_DEF,
	parameter int GROUP_BYTES = tmbb_pkg::GROUP_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] now_ms,
	input  logic [7:0]  tag,
	input  logic [15:0] entry_type,
	input  logic [15:0] body_len,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic        status,
	output logic [7:0]  replay_byte,
	output logic        last
);

	tmbb_pkg::cmd_t cmd;
	tmbb_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	tmbb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tmbb_dp #(
		.GROUP_COUNT (GROUP_COUNT),
		.GROUP_BYTES (GROUP_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.action      (action),
		.now_ms      (now_ms),
		.tag         (tag),
		.entry_type  (entry_type),
		.body_len    (body_len),
		.data_byte   (data_byte),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.kind        (kind),
		.status      (status),
		.replay_byte (replay_byte),
		.last        (last)
	);

	// one transaction in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while previous item still in work");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == tmbb_pkg::KIND_STATUS |-> last)
		else $error("status result without last");

	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == tmbb_pkg::KIND_BYTE |-> status == tmbb_pkg::STAT_OK)
		else $error("replayed byte flagged busy");

	a_no_load_over: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output register overwritten");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the tagged message batch buffer.
module tb;

	localparam int NGRP = tmbb_pkg::GROUP_COUNT_DEF;
	localparam int NBYTES = tmbb_pkg::GROUP_BYTES_DEF;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  action;
	logic [31:0] now_ms;
	logic [7:0]  tag;
	logic [15:0] entry_type;
	logic [15:0] body_len;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic        kind;
	logic        status;
	logic [7:0]  replay_byte;
	logic        last;

	typedef struct packed {
		logic       kind;
		logic       status;
		logic [7:0] data;
		logic       last;
	} result_t;

	tagged_message_batch_buffer DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .action(action), .now_ms(now_ms),
		.tag(tag), .entry_type(entry_type), .body_len(body_len), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall), .kind(kind), .status(status),
		.replay_byte(replay_byte), .last(last)
	);

	// shadow state of the buffer
	logic [31:0] timeout_ms;
	logic        grp_act [NGRP];
	logic [7:0]  grp_tag [NGRP];
	int unsigned grp_fill [NGRP];
	logic [31:0] grp_stamp [NGRP];
	logic [7:0]  grp_store [NGRP*NBYTES];
	int unsigned wr_grp;
	int unsigned pend_bytes;
	logic        discard;

	result_t expected_results[$];
	int errors = 0;
	int n_items = 0;
	int n_results = 0;
	int idle_cycles = 0;
	int unsigned stall_cnt = 0;
	logic [31:0] clock_ms = 0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// watchdog: cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic void shadow_reset();
		timeout_ms = tmbb_pkg::TIMEOUT_RESET;
		for (int i = 0; i < NGRP; i++) begin
			grp_act[i] = 0;
			grp_tag[i] = 0;
			grp_fill[i] = 0;
			grp_stamp[i] = 0;
		end
		wr_grp = 0;
		pend_bytes = 0;
		discard = 0;
	endfunction

	function automatic void release_group(int g);
		grp_act[g] = 0;
		grp_fill[g] = 0;
		if (wr_grp == g) begin
			pend_bytes = 0;
			discard = 0;
		end
	endfunction

	function automatic void push_result(logic k, logic s, logic [7:0] d, logic l);
		result_t r;
		r.kind = k;
		r.status = s;
		r.data = d;
		r.last = l;
		expected_results.push_back(r);
	endfunction

	function automatic int lookup_tag(logic [7:0] t);
		for (int i = 0; i < NGRP; i++)
			if (grp_act[i] && grp_tag[i] == t)
				return i;
		return -1;
	endfunction

	function automatic void predict_buffer(logic [1:0] act, logic [31:0] tnow, logic [7:0] t,
			logic [15:0] mtype, logic [15:0] plen, logic [7:0] d);
		int g;
		int unsigned base;
		case (act)
			tmbb_pkg::ACT_TICK: begin
				for (int i = 0; i < NGRP; i++)
					if (grp_act[i] && (tnow - grp_stamp[i]) > timeout_ms)
						release_group(i);
			end
			tmbb_pkg::ACT_START: begin
				g = lookup_tag(t);
				if (g < 0) begin
					for (int i = 0; i < NGRP; i++)
						if (!grp_act[i]) begin
							g = i;
							grp_act[i] = 1;
							grp_tag[i] = t;
							grp_fill[i] = 0;
							break;
						end
				end
				if (g < 0 || grp_fill[g] + tmbb_pkg::HEADER_LEN + plen > NBYTES) begin
					pend_bytes = plen;
					discard = 1;
					push_result(tmbb_pkg::KIND_STATUS, tmbb_pkg::STAT_BUSY, 8'h00, 1'b1);
				end else begin
					base = g * NBYTES + grp_fill[g];
					grp_store[base] = mtype[7:0];
					grp_store[base+1] = mtype[15:8];
					grp_store[base+2] = plen[7:0];
					grp_store[base+3] = plen[15:8];
					grp_fill[g] += tmbb_pkg::HEADER_LEN;
					grp_stamp[g] = tnow;
					wr_grp = g;
					pend_bytes = plen;
					discard = 0;
					push_result(tmbb_pkg::KIND_STATUS, tmbb_pkg::STAT_OK, 8'h00, 1'b1);
				end
			end
			tmbb_pkg::ACT_BYTE: begin
				if (pend_bytes != 0) begin
					pend_bytes--;
					if (!discard && grp_act[wr_grp] && grp_fill[wr_grp] < NBYTES) begin
						grp_store[wr_grp*NBYTES + grp_fill[wr_grp]] = d;
						grp_fill[wr_grp]++;
					end
				end
			end
			default: begin
				g = lookup_tag(t);
				if (g < 0) begin
					push_result(tmbb_pkg::KIND_STATUS, tmbb_pkg::STAT_OK, 8'h00, 1'b1);
				end else if (grp_fill[g] == 0) begin
					release_group(g);
					push_result(tmbb_pkg::KIND_STATUS, tmbb_pkg::STAT_OK, 8'h00, 1'b1);
				end else begin
					for (int i = 0; i < grp_fill[g]; i++)
						push_result(tmbb_pkg::KIND_BYTE, tmbb_pkg::STAT_OK,
							grp_store[g*NBYTES + i], i + 1 == grp_fill[g]);
					release_group(g);
				end
			end
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (expected_results.size() == 0) begin
				$error("unexpected result kind=%0d status=%0d byte=%0h last=%0d",
					kind, status, replay_byte, last);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (kind !== e.kind) begin
					$error("kind: expected %0d, got %0d", e.kind, kind);
					errors++;
				end
				if (status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, status);
					errors++;
				end
				if (replay_byte !== e.data) begin
					$error("replay_byte: expected %0h, got %0h", e.data, replay_byte);
					errors++;
				end
				if (last !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, last);
					errors++;
				end
			end
		end
	end

	// receiver holds off for a drawn number of cycles after each result
	always @(posedge clk) begin
		int unsigned w;
		if (!arst_n) begin
			out_stall <= 0;
			stall_cnt <= 0;
		end else if (out_valid && !out_stall) begin
			w = $urandom_range(0, 9);
			out_stall <= (w != 0);
			stall_cnt <= w;
		end else if (out_stall) begin
			if (stall_cnt <= 1)
				out_stall <= 0;
			stall_cnt <= stall_cnt - 1;
		end
	end

	task automatic send_item(logic [1:0] act, logic [31:0] tnow, logic [7:0] t,
			logic [15:0] mtype, logic [15:0] plen, logic [7:0] d);
		int unsigned gap;
		gap = $urandom_range(0, 9);
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		action <= act;
		now_ms <= tnow;
		tag <= t;
		entry_type <= mtype;
		body_len <= plen;
		data_byte <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_buffer(act, tnow, t, mtype, plen, d);
		n_items++;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (expected_results.size() != 0)
			@(posedge clk);
		// margin after the last expected result before the next step
		repeat (20) @(posedge clk);
	endtask

	task automatic write_timeout(logic [31:0] v);
		drain();
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		timeout_ms = v;
	endtask

	task automatic send_message(logic [7:0] t, logic [15:0] plen, int nbytes);
		send_item(tmbb_pkg::ACT_START, clock_ms, t, 16'($urandom), plen, 8'($urandom));
		for (int i = 0; i < nbytes; i++)
			send_item(tmbb_pkg::ACT_BYTE, 32'($urandom), 8'($urandom), 16'($urandom),
				16'($urandom), 8'($urandom));
	endtask

	task automatic test_directed();
		send_item(tmbb_pkg::ACT_BYTE, 32'd0, 8'h00, 16'h0000, 16'h0000, 8'hFF); // stray byte
		send_item(tmbb_pkg::ACT_EXEC, 32'd0, 8'hFF, 16'h0000, 16'h0000, 8'h00); // missing
		send_message(8'h00, 16'd0, 0);
		send_item(tmbb_pkg::ACT_EXEC, 32'd0, 8'h00, 16'h0000, 16'h0000, 8'h00);
		// claimed but busy
		send_item(tmbb_pkg::ACT_START, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'h00);
		send_item(tmbb_pkg::ACT_BYTE, 32'd0, 8'h00, 16'h0000, 16'h0000, 8'hAA); // dropped
		send_item(tmbb_pkg::ACT_EXEC, 32'd0, 8'hFF, 16'h0000, 16'h0000, 8'h00); // empty
		send_item(tmbb_pkg::ACT_START, 32'd10, 8'h11, 16'hA55A, 16'd60, 8'h00); // exact fit
		for (int i = 0; i < 60; i++)
			send_item(tmbb_pkg::ACT_BYTE, 32'd0, 8'h00, 16'h0000, 16'h0000, 8'(i * 37));
		send_item(tmbb_pkg::ACT_START, 32'd10, 8'h11, 16'h0001, 16'd0, 8'h00); // full: busy
		send_item(tmbb_pkg::ACT_EXEC, 32'd0, 8'h11, 16'h0000, 16'h0000, 8'h00);
		send_item(tmbb_pkg::ACT_START, 32'd20, 8'h22, 16'h1234, 16'd5, 8'h00);
		send_item(tmbb_pkg::ACT_BYTE, 32'd0, 8'h00, 16'h0000, 16'h0000, 8'h01);
		send_item(tmbb_pkg::ACT_START, 32'd20, 8'h22, 16'h5678, 16'd1, 8'h00); // interrupted
		send_item(tmbb_pkg::ACT_BYTE, 32'd0, 8'h00, 16'h0000, 16'h0000, 8'h02);
		send_item(tmbb_pkg::ACT_START, 32'd20, 8'h33, 16'h9ABC, 16'd3, 8'h00);
		// frees the write group
		send_item(tmbb_pkg::ACT_TICK, 32'd20 + tmbb_pkg::TIMEOUT_RESET + 32'd1, 8'h00,
			16'h0000, 16'h0000, 8'h00);
		send_item(tmbb_pkg::ACT_BYTE, 32'd0, 8'h00, 16'h0000, 16'h0000, 8'h03);
		send_item(tmbb_pkg::ACT_EXEC, 32'd0, 8'h22, 16'h0000, 16'h0000, 8'h00);
		send_item(tmbb_pkg::ACT_EXEC, 32'd0, 8'h33, 16'h0000, 16'h0000, 8'h00);
	endtask

	task automatic test_random(int target, logic [31:0] tmo);
		int r;
		int plen;
		int first_item;
		write_timeout(tmo);
		first_item = n_items;
		clock_ms = 32'($urandom);
		while (n_items - first_item < target) begin
			r = $urandom_range(0, 9);
			clock_ms = clock_ms + $urandom_range(0, 3000);
			if (r < 5) begin
				plen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, 14);
				send_message(8'($urandom_range(0, 5)), 16'(plen),
					($urandom_range(0, 4) == 0) ? $urandom_range(0, plen < 16 ? plen : 16)
					: (plen < 16 ? plen : 2));
			end else if (r < 7) begin
				send_item(tmbb_pkg::ACT_EXEC, 32'($urandom), 8'($urandom_range(0, 6)),
					16'($urandom), 16'($urandom), 8'($urandom));
			end else if (r < 9) begin
				send_item(tmbb_pkg::ACT_TICK, clock_ms, 8'($urandom), 16'($urandom),
					16'($urandom), 8'($urandom));
			end else begin
				send_item(tmbb_pkg::ACT_BYTE, 32'($urandom), 8'($urandom), 16'($urandom),
					16'($urandom), 8'($urandom));
			end
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_valid = 0;
		cfg_data = 0;
		in_valid = 0;
		action = tmbb_pkg::ACT_TICK;
		now_ms = 0;
		tag = 0;
		entry_type = 0;
		body_len = 0;
		data_byte = 0;
		shadow_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random(40, 32'd0);
		test_random(40, 32'hFFFF_FFFF);
		test_random(40, 32'd1500);
		test_random(30, tmbb_pkg::TIMEOUT_RESET);
		drain();
		$display("Covered %0d input items and %0d results over four timeout settings.",
			n_items, n_results);
		if (errors == 0 && expected_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
